### sv/gesture_step_sequencer_core_assert.svh
// Assertion macros for the gesture step sequencer core.
// Included by the top level; no other dependencies.
`ifndef GESTURE_STEP_SEQUENCER_CORE_ASSERT_SVH
`define GESTURE_STEP_SEQUENCER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/gss_pkg.sv
// Shared types, codes and constants of the gesture step sequencer.
// No dependencies.
package gss_pkg;

    typedef enum logic [2:0] {
        ACT_PRESS   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_POLAR   = 3'd2,
        ACT_INTEG   = 3'd3,
        ACT_ACCEL   = 3'd4
    } action_t;

    localparam logic [2:0] CFG_OUTER    = 3'd0;
    localparam logic [2:0] CFG_INNER    = 3'd1;
    localparam logic [2:0] CFG_TILT     = 3'd2;
    localparam logic [2:0] CFG_HOLDOFF  = 3'd3;
    localparam logic [2:0] CFG_VELOCITY = 3'd4;

    localparam logic [7:0] OUTER_RST    = 8'd56;
    localparam logic [7:0] INNER_RST    = 8'd16;
    localparam logic [7:0] TILT_RST     = 8'd224;
    localparam logic [7:0] HOLDOFF_RST  = 8'd50;
    localparam logic [6:0] VELOCITY_RST = 7'd100;

    localparam logic [6:0] NOTE_EVEN = 7'd48;
    localparam logic [6:0] NOTE_ODD  = 7'd60;
    localparam logic [6:0] NOTE_LAST = 7'd43;
    localparam logic [6:0] NOTE_MAX  = 7'd127;

    localparam int Y_SHIFT = 12;
    localparam int X_SHIFT = 14;
    localparam int SUM_W   = 22;

    typedef struct packed {
        action_t            action;
        logic [7:0]         radius;
        logic [2:0]         octant;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
    } item_t;

    typedef struct packed {
        logic [7:0] outer_radius;
        logic [7:0] inner_radius;
        logic [7:0] tilt_threshold;
        logic [7:0] holdoff_count;
        logic [6:0] velocity;
    } cfg_t;

    typedef struct packed {
        logic       note_on;
        logic [6:0] note;
        logic [6:0] note_velocity;
        logic       clear_integration;
        logic       last;
    } evt_t;

    typedef struct packed {
        evt_t       r0;
        evt_t       r1;
        logic [1:0] nres;
    } pair_t;

    function automatic logic [6:0] reset_note(int idx, int count);
        logic [6:0] n;
        if (idx == count - 1)
            n = NOTE_LAST;
        else if ((idx % 2) == 1)
            n = NOTE_ODD;
        else
            n = NOTE_EVEN;
        return n;
    endfunction

endpackage

### sv/gss_step_unit.sv
// Sequencer state and the single-pass logic that turns one event into up to two notes.
// Depends on gss_pkg.
module gss_step_unit #(
    parameter int STEP_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  gss_pkg::item_t item,
    input  gss_pkg::cfg_t  cfg,
    output gss_pkg::pair_t pair
);
    import gss_pkg::*;

    localparam int SW = $clog2(STEP_COUNT);

    logic [6:0]    step_notes_reg [STEP_COUNT];
    logic [SW-1:0] cur_step_reg, cur_step_next;
    logic [6:0]    cur_note_reg, cur_note_next;
    logic          recording_reg, recording_next;
    logic [6:0]    base_note_reg, base_note_next;
    logic [7:0]    holdoff_reg, holdoff_next;
    logic          retrig_reg, retrig_next;
    logic          armed_reg, armed_next;
    logic          tbl_we;
    logic [6:0]    tbl_wdata;

    logic [SW-1:0]          sel_step;
    logic [SW-1:0]          nxt_step;
    logic [6:0]             sel_note;
    logic                   oct_ok;
    logic signed [SUM_W-1:0] sum;
    logic [6:0]             tuned;

    function automatic evt_t mk_evt(logic on, logic [6:0] n, logic [6:0] vel, logic clr);
        evt_t e;
        e.note_on           = on;
        e.note              = n;
        e.note_velocity     = on ? vel : 7'd0;
        e.clear_integration = clr;
        e.last              = 1'b0;
        return e;
    endfunction

    assign oct_ok   = 32'(item.octant) < STEP_COUNT;
    assign nxt_step = ((32'(cur_step_reg) + 32'd1) == STEP_COUNT) ? '0 : cur_step_reg + 1'b1;
    assign sel_step = (item.action == ACT_ACCEL) ? nxt_step : SW'(item.octant);
    assign sel_note = step_notes_reg[sel_step];

    assign sum = SUM_W'($signed({1'b0, base_note_reg}))
               + SUM_W'(item.value_y >>> Y_SHIFT)
               + SUM_W'(item.value_x >>> X_SHIFT);

    always_comb
    begin
        if (sum[SUM_W-1])
            tuned = 7'd0;
        else if (|sum[SUM_W-2:7])
            tuned = NOTE_MAX;
        else
            tuned = sum[6:0];
    end

    always_comb
    begin
        logic [7:0] h;
        h              = holdoff_reg;
        cur_step_next  = cur_step_reg;
        cur_note_next  = cur_note_reg;
        recording_next = recording_reg;
        base_note_next = base_note_reg;
        retrig_next    = retrig_reg;
        armed_next     = armed_reg;
        tbl_we         = 1'b0;
        tbl_wdata      = tuned;
        pair.r0        = mk_evt(1'b0, cur_note_reg, cfg.velocity, 1'b0);
        pair.r1        = mk_evt(1'b1, sel_note, cfg.velocity, 1'b0);
        pair.nres      = 2'd0;
        case (item.action)
            ACT_PRESS:
            begin
                recording_next = 1'b1;
                base_note_next = cur_note_reg;
                pair.r0        = mk_evt(1'b0, cur_note_reg, cfg.velocity, 1'b1);
                pair.nres      = 2'd1;
            end
            ACT_RELEASE:
            begin
                recording_next = 1'b0;
                h              = 8'd0;
            end
            ACT_POLAR:
            begin
                if (!recording_reg)
                begin
                    if (item.radius > cfg.outer_radius)
                    begin
                        armed_next = 1'b1;
                        if (oct_ok)
                        begin
                            if (sel_step != cur_step_reg)
                            begin
                                cur_step_next = sel_step;
                                cur_note_next = sel_note;
                                pair.nres     = 2'd2;
                            end
                            else if (retrig_reg)
                            begin
                                retrig_next = 1'b0;
                                pair.r0     = mk_evt(1'b1, cur_note_reg, cfg.velocity, 1'b0);
                                pair.nres   = 2'd1;
                            end
                        end
                    end
                    else if (item.radius < cfg.inner_radius)
                    begin
                        if (armed_reg)
                            pair.nres = 2'd1;
                        retrig_next = 1'b1;
                        armed_next  = 1'b0;
                    end
                end
            end
            ACT_INTEG:
            begin
                if (recording_reg && tuned != cur_note_reg)
                begin
                    tbl_we        = 1'b1;
                    cur_note_next = tuned;
                    pair.r1       = mk_evt(1'b1, tuned, cfg.velocity, 1'b0);
                    pair.nres     = 2'd2;
                end
            end
            ACT_ACCEL:
            begin
                if (item.value_y[7:0] > cfg.tilt_threshold && holdoff_reg == 8'd0)
                begin
                    cur_step_next = nxt_step;
                    cur_note_next = sel_note;
                    pair.nres     = 2'd2;
                    h             = cfg.holdoff_count;
                end
                if (h != 8'd0)
                    h = h - 8'd1;
            end
            default:
            begin
                pair.nres = 2'd0;
            end
        endcase
        holdoff_next = h;
        if (pair.nres == 2'd1)
            pair.r0.last = 1'b1;
        if (pair.nres == 2'd2)
            pair.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STEP_COUNT; i++)
                step_notes_reg[i] <= reset_note(i, STEP_COUNT);
            cur_step_reg  <= '0;
            cur_note_reg  <= reset_note(0, STEP_COUNT);
            recording_reg <= 1'b0;
            base_note_reg <= 7'd0;
            holdoff_reg   <= 8'd0;
            retrig_reg    <= 1'b0;
            armed_reg     <= 1'b0;
        end
        else if (fire)
        begin
            if (tbl_we)
                step_notes_reg[cur_step_reg] <= tbl_wdata;
            cur_step_reg  <= cur_step_next;
            cur_note_reg  <= cur_note_next;
            recording_reg <= recording_next;
            base_note_reg <= base_note_next;
            holdoff_reg   <= holdoff_next;
            retrig_reg    <= retrig_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

### sv/gss_out_queue.sv
// Two-entry result register that holds the notes of one event and streams them out.
// Depends on gss_pkg.
module gss_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  gss_pkg::pair_t pair,
    input  logic           pop,
    output logic           valid,
    output logic           free,
    output logic [1:0]     count,
    output gss_pkg::evt_t  head
);
    import gss_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    evt_t       head_reg, head_next;
    evt_t       tail_reg, tail_next;

    assign valid = cnt_reg != 2'd0;
    assign free  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign count = cnt_reg;
    assign head  = head_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (load)
        begin
            cnt_next  = pair.nres;
            head_next = pair.r0;
            tail_next = pair.r1;
        end
        else if (pop && valid)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

### sv/gesture_step_sequencer_core.sv
// Top level of the gesture step sequencer: input register, settings, step unit, result queue.
// Depends on gss_pkg, gss_step_unit, gss_out_queue and the assertion header.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tuser action, s_tdata stick and tilt values
//  m_*       out        m_tvalid/m_tready  m_tdata note event, m_tlast final event
//  cfg_*     in         cfg_wr_en          cfg_index, cfg_data
//
// An event is held in the input register and resolved combinationally into zero, one or
// two notes, which leave the result queue one per cycle while m_tready is high.
// The queue sets the rate: with m_tready high, one event per cycle if it yields at most one
// note; a two-note event holds up the next. Reset is asynchronous and active low and
// restores the note table and settings. A stalled m_tready backs up into s_tready.
`include "gesture_step_sequencer_core_assert.svh"
module gesture_step_sequencer_core #(
    parameter int STEP_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // action
    input  logic [79:0] s_tdata,   // radius, octant, value_x, value_y, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // note_on, note, note_velocity, clear_integration
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import gss_pkg::*;

    logic  in_valid_reg, in_valid_next;
    item_t item_reg;
    cfg_t  cfg_reg;
    logic  fire;
    logic  s_accept;
    logic  q_free;
    logic [1:0] q_count;
    pair_t pair;
    evt_t  head;

    assign fire     = in_valid_reg && q_free;
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.action  <= action_t'(s_tuser);
            item_reg.radius  <= s_tdata[7:0];
            item_reg.octant  <= s_tdata[10:8];
            item_reg.value_x <= s_tdata[42:11];
            item_reg.value_y <= s_tdata[74:43];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outer_radius   <= OUTER_RST;
            cfg_reg.inner_radius   <= INNER_RST;
            cfg_reg.tilt_threshold <= TILT_RST;
            cfg_reg.holdoff_count  <= HOLDOFF_RST;
            cfg_reg.velocity       <= VELOCITY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OUTER:    cfg_reg.outer_radius   <= cfg_data;
                CFG_INNER:    cfg_reg.inner_radius   <= cfg_data;
                CFG_TILT:     cfg_reg.tilt_threshold <= cfg_data;
                CFG_HOLDOFF:  cfg_reg.holdoff_count  <= cfg_data;
                CFG_VELOCITY: cfg_reg.velocity       <= cfg_data[6:0];
                default:      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    gss_step_unit #(
        .STEP_COUNT(STEP_COUNT)
    ) u_step (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (fire),
        .item (item_reg),
        .cfg  (cfg_reg),
        .pair (pair)
    );

    gss_out_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .load (fire),
        .pair (pair),
        .pop  (m_tready),
        .valid(m_tvalid),
        .free (q_free),
        .count(q_count),
        .head (head)
    );

    assign m_tdata = {head.clear_integration, head.note_velocity, head.note, head.note_on};
    assign m_tlast = head.last;

    `GSS_ASSERT_IMP(a_pair_head_not_last, clk, rst_n, q_count == 2'd2, !m_tlast)
    `GSS_ASSERT_IMP(a_full_blocks_fire, clk, rst_n, q_count == 2'd2, !fire)
    `GSS_ASSERT_IMP(a_stall_means_busy, clk, rst_n, !s_tready, in_valid_reg && !q_free)
    `GSS_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, s_accept, in_valid_reg)

endmodule
